[sv/pmdd_pkg.sv]
// Package for the particle-mesh density deposit block.
// Holds field widths, operation and status codes and register defaults.
// No dependencies.
package pmdd_pkg;

  localparam int GridNDefault = 32;
  localparam int SearchLimit  = 16;

  localparam int OpW     = 2;
  localparam int IdxW    = 5;
  localparam int CoordW  = 32;
  localparam int MassW   = 32;
  localparam int DensW   = 48;
  localparam int StatW   = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 31;

  localparam int DimsW   = 2;
  localparam int PtsW    = 6;
  localparam int SpaceW  = 31;
  localparam int RadW    = 31;
  localparam int FracW   = 17;

  // floor(x / 3) = (x * Recip3) >> Recip3Shift for any 32-bit x
  localparam logic [MassW-1:0] Recip3      = 32'hAAAA_AAAB;
  localparam int               Recip3Shift = 33;

  typedef enum logic [OpW-1:0] {
    OP_WRITE_COORD = 2'd0,
    OP_DEPOSIT     = 2'd1,
    OP_READ        = 2'd2,
    OP_READ_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_STEP_BOUND = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIMS   = 3'd0,
    CFG_POINTS = 3'd1,
    CFG_SPACE  = 3'd2,
    CFG_BEN    = 3'd3,
    CFG_BRAD   = 3'd4,
    CFG_BFRAC  = 3'd5
  } cfg_idx_t;

  localparam logic [DimsW-1:0]  DimsReset   = 2'd3;
  localparam logic [PtsW-1:0]   PointsReset = 6'd32;
  localparam logic [SpaceW-1:0] SpaceReset  = 31'd65536;
  localparam logic [FracW-1:0]  FracOne     = 17'd65536;

endpackage

[sv/pmdd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pmdd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/particle_mesh_density_deposit_core.sv]
// Top level of the particle-mesh density deposit block (box stencil).
// Depends on pmdd_pkg and pmdd_ram (coordinate table and density store).
//
//   channel | signals                              | moves
//   req     | req_valid, req_stall, opcode..read_z | one item per transaction
//   rsp     | rsp_valid, rsp_stall, status..density| one result per transaction
//   cfg     | cfg_write, cfg_index, cfg_data       | register write, no wait
//
// After reset a clearing pass writes zero to all GRID_N^3 density cells,
// one a cycle; req_stall is high throughout.
// Coordinate write and out-of-range reads go straight to the rsp register; a
// cell read reads the density RAM first. Deposit: search probes (up to 16 per
// axis), the bulge test, the bulge mass product, one divide-by-three step per
// axis for the share, then a read per skipped and a read and a write per
// updated neighbour on the density RAM port, and a load of the rsp register.
// One item is in work at a time; a finished result waits in the rsp register
// while the next item is taken.
module particle_mesh_density_deposit_core #(
  parameter int GRID_N = pmdd_pkg::GridNDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [pmdd_pkg::OpW-1:0]        opcode,
  input  logic [pmdd_pkg::IdxW-1:0]       grid_index,
  input  logic signed [pmdd_pkg::CoordW-1:0] coord_value,
  input  logic signed [pmdd_pkg::CoordW-1:0] pos_x,
  input  logic signed [pmdd_pkg::CoordW-1:0] pos_y,
  input  logic signed [pmdd_pkg::CoordW-1:0] pos_z,
  input  logic [pmdd_pkg::MassW-1:0]      particle_mass,
  input  logic [pmdd_pkg::IdxW-1:0]       read_x,
  input  logic [pmdd_pkg::IdxW-1:0]       read_y,
  input  logic [pmdd_pkg::IdxW-1:0]       read_z,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [pmdd_pkg::StatW-1:0]      status,
  output logic [pmdd_pkg::IdxW-1:0]       cell_x,
  output logic [pmdd_pkg::IdxW-1:0]       cell_y,
  output logic [pmdd_pkg::IdxW-1:0]       cell_z,
  output logic                            in_bulge,
  output logic [pmdd_pkg::DensW-1:0]      density,
  input  logic                            cfg_write,
  input  logic [pmdd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pmdd_pkg::CfgW-1:0]       cfg_data
);
  import pmdd_pkg::*;

  localparam int Cells = GRID_N * GRID_N * GRID_N;
  localparam int IW    = $clog2(GRID_N);
  localparam int NW    = $clog2(GRID_N + 1);
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(Cells + 1);
  localparam int EW    = IW + 2;
  localparam int MpW   = MassW + FracW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SCMP, S_BLG, S_MUL, S_DIV,
    S_DRD, S_DWR, S_RRD, S_RDONE, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [DimsW-1:0]  dims;
  logic [PtsW-1:0]   gpts;
  logic [SpaceW-1:0] spacing;
  logic              ben;
  logic [RadW-1:0]   brad;
  logic [FracW-1:0]  bfrac;

  // held transaction
  opcode_t            op;
  logic signed [CoordW-1:0] px, py, pz;
  logic [MassW-1:0]   mass;
  logic [IW-1:0]      rx, ry, rz;

  // search
  logic [1:0]    axis;
  logic [IW-1:0] first, last;
  logic [4:0]    steps;
  logic [IW-1:0] cx, cy, cz;

  // bulge, share, stencil
  logic [2:0]        bcnt;
  logic [63:0]       sq, acc;
  logic [61:0]       rr;
  logic [MassW-1:0]  q;
  logic [1:0]        dcnt;
  logic [MassW-1:0]  share;
  logic [1:0]        ox, oy, oz;
  logic [CW-1:0]     clr;

  // result held until the rsp register is free
  status_t           res_status;
  logic              res_bulge;
  logic [DensW-1:0]  res_dens;

  // memories
  logic              cg_we;
  logic [IW-1:0]     cg_waddr, cg_raddr;
  logic [CoordW-1:0] cg_rdata;
  logic              dn_we;
  logic [AW-1:0]     dn_addr;
  logic [DensW-1:0]  dn_wdata, dn_rdata;

  pmdd_ram #(.WIDTH(CoordW), .DEPTH(GRID_N)) u_coords (
    .clk, .we(cg_we), .waddr(cg_waddr), .wdata(coord_value),
    .raddr(cg_raddr), .rdata(cg_rdata)
  );

  pmdd_ram #(.WIDTH(DensW), .DEPTH(Cells)) u_density (
    .clk, .we(dn_we), .waddr(dn_addr), .wdata(dn_wdata),
    .raddr(dn_addr), .rdata(dn_rdata)
  );

  function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] x, logic [IW-1:0] y,
                                              logic [IW-1:0] z);
    cell_addr = AW'(AW'(z) * AW'(GRID_N * GRID_N) + AW'(y) * AW'(GRID_N) + AW'(x));
  endfunction

  function automatic logic [CoordW-1:0] mag(logic [CoordW-1:0] v);
    mag = v[CoordW-1] ? CoordW'(-v) : v;
  endfunction

  // points in use and effective dimensions
  logic [NW-1:0] pts;
  logic [1:0]    deff;
  always_comb begin
    if (gpts < PtsW'(2)) begin
      pts = NW'(2);
    end else if (int'(gpts) > GRID_N) begin
      pts = NW'(GRID_N);
    end else begin
      pts = NW'(gpts);
    end
    deff = (dims == 2'd0) ? 2'd1 : dims;
  end

  // search probe
  logic [IW-1:0]        mid;
  logic signed [CoordW-1:0] spos;
  logic signed [34:0]   p2, g2, hi, lo, spx;
  logic                 hit, above;
  always_comb begin
    mid = IW'(({1'b0, first} + {1'b0, last}) >> 1);
    unique case (axis)
      2'd0:    spos = px;
      2'd1:    spos = py;
      default: spos = pz;
    endcase
    p2    = 35'(spos) <<< 1;
    g2    = 35'($signed(cg_rdata)) <<< 1;
    spx   = $signed({4'b0, spacing});
    hi    = g2 + spx;
    lo    = g2 - spx;
    hit   = (p2 < hi) && (p2 > lo);
    above = (p2 >= hi);
  end

  // stencil cell
  logic [EW-1:0] ix, iy, iz;
  logic          cell_ok, cell_last;
  logic [DensW:0] sum;
  always_comb begin
    ix = EW'(cx) + EW'(ox);
    iy = EW'(cy) + EW'(oy);
    iz = EW'(cz) + EW'(oz);
    cell_ok = (ix != '0) && (iy != '0) && (iz != '0) &&
              (ix <= EW'(pts)) && (iy <= EW'(pts)) && (iz <= EW'(pts));
    cell_last = (ox == 2'd2) && (oy == ((deff >= 2'd2) ? 2'd2 : 2'd1)) &&
                (oz == ((deff == 2'd3) ? 2'd2 : 2'd1));
    sum = {1'b0, dn_rdata} + (DensW + 1)'(share);
  end

  logic req_take;
  assign req_take = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  // memory ports
  always_comb begin
    cg_we    = req_take && (opcode == OP_WRITE_COORD) && (int'(grid_index) < GRID_N);
    cg_waddr = IW'(grid_index);
    cg_raddr = mid;
    dn_we    = 1'b0;
    dn_wdata = '0;
    dn_addr  = cell_addr(rx, ry, rz);
    if (state == S_BLG) begin
      unique case (bcnt)
        3'd0:    cg_raddr = cx;
        3'd1:    cg_raddr = cy;
        default: cg_raddr = cz;
      endcase
    end
    unique case (state)
      S_CLR: begin
        dn_we   = 1'b1;
        dn_addr = AW'(clr);
      end
      S_DRD, S_DWR: begin
        dn_addr = cell_addr(IW'(ix - EW'(1)), IW'(iy - EW'(1)), IW'(iz - EW'(1)));
        if (state == S_DWR) begin
          dn_we    = 1'b1;
          dn_wdata = sum[DensW] ? {DensW{1'b1}} : sum[DensW-1:0];
        end
      end
      S_RDONE: dn_we = (op == OP_READ_CLEAR);
      default: ;
    endcase
  end

  // bulge mass product and one divide-by-three step
  logic [FracW-1:0] fclip;
  logic [MpW-1:0]   mprod;
  logic [63:0]      qprod;
  logic [MassW-1:0] q3;
  always_comb begin
    fclip = (bfrac > FracOne) ? FracOne : bfrac;
    mprod = MpW'(mass) * MpW'(fclip);
    qprod = 64'(q) * 64'(Recip3);
    q3    = MassW'(qprod >> Recip3Shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      rsp_valid <= 1'b0;
      dims      <= DimsReset;
      gpts      <= PointsReset;
      spacing   <= SpaceReset;
      ben       <= 1'b0;
      brad      <= '0;
      bfrac     <= FracOne;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_DIMS:   dims    <= cfg_data[DimsW-1:0];
          CFG_POINTS: gpts    <= cfg_data[PtsW-1:0];
          CFG_SPACE:  spacing <= cfg_data[SpaceW-1:0];
          CFG_BEN:    ben     <= cfg_data[0];
          CFG_BRAD:   brad    <= cfg_data[RadW-1:0];
          CFG_BFRAC:  bfrac   <= cfg_data[FracW-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(Cells - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            op         <= opcode_t'(opcode);
            px         <= pos_x;
            py         <= pos_y;
            pz         <= pos_z;
            mass       <= particle_mass;
            rx         <= IW'(read_x);
            ry         <= IW'(read_y);
            rz         <= IW'(read_z);
            res_bulge  <= 1'b0;
            res_dens   <= '0;
            cx         <= '0;
            cy         <= '0;
            cz         <= '0;
            axis       <= 2'd0;
            first      <= '0;
            last       <= IW'(pts - NW'(1));
            steps      <= '0;
            unique case (opcode_t'(opcode))
              OP_WRITE_COORD: begin
                res_status <= (int'(grid_index) >= GRID_N) ? ST_RANGE : ST_OK;
                state      <= S_FIN;
              end
              OP_DEPOSIT: begin
                res_status <= ST_OK;
                state      <= S_SRD;
              end
              default: begin
                if (NW'(read_x) >= pts || NW'(read_y) >= pts || NW'(read_z) >= pts ||
                    int'(read_x) >= GRID_N || int'(read_y) >= GRID_N ||
                    int'(read_z) >= GRID_N) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_RRD;
                end
              end
            endcase
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          logic          found;
          logic [IW-1:0] hit_cell;
          found    = 1'b1;
          hit_cell = mid;
          if (hit) begin
            hit_cell = mid;
          end else if (above) begin
            if (NW'(mid) == pts - NW'(2)) hit_cell = IW'(pts - NW'(1));
            else begin
              found = 1'b0;
              first <= mid;
            end
          end else begin
            if (mid == '0) hit_cell = '0;
            else begin
              found = 1'b0;
              last <= mid;
            end
          end
          if (found) begin
            unique case (axis)
              2'd0:    cx <= hit_cell;
              2'd1:    cy <= hit_cell;
              default: cz <= hit_cell;
            endcase
            if (axis + 2'd1 < deff) begin
              axis  <= axis + 2'd1;
              first <= '0;
              last  <= IW'(pts - NW'(1));
              steps <= '0;
              state <= S_SRD;
            end else begin
              ox   <= 2'd0;
              oy   <= (deff >= 2'd2) ? 2'd0 : 2'd1;
              oz   <= (deff == 2'd3) ? 2'd0 : 2'd1;
              bcnt <= '0;
              q    <= mass;
              dcnt <= '0;
              state <= (deff == 2'd3 && ben) ? S_BLG : S_DIV;
            end
          end else if (steps == 5'(SearchLimit - 1)) begin
            res_status <= ST_STEP_BOUND;
            cx    <= '0;
            cy    <= '0;
            cz    <= '0;
            state <= S_FIN;
          end else begin
            steps <= steps + 5'd1;
            state <= S_SRD;
          end
        end
        S_BLG: begin
          bcnt <= bcnt + 3'd1;
          if (bcnt >= 3'd1 && bcnt <= 3'd3) begin
            sq <= 64'(mag(cg_rdata)) * 64'(mag(cg_rdata));
          end
          if (bcnt == 3'd2) acc <= sq;
          if (bcnt == 3'd3) begin
            acc <= acc + sq;
            rr  <= 62'(brad) * 62'(brad);
          end
          if (bcnt == 3'd4) acc <= acc + sq;
          if (bcnt == 3'd5) begin
            if (acc < 64'(rr)) begin
              res_bulge <= 1'b1;
              state     <= S_MUL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          // mass * fraction / 65536, then one divide by three per axis
          q     <= mprod[MassW+15:16];
          state <= S_DIV;
        end
        S_DIV: begin
          q    <= q3;
          dcnt <= dcnt + 2'd1;
          if (dcnt == deff - 2'd1) begin
            share <= q3;
            state <= S_DRD;
          end
        end
        S_DRD, S_DWR: begin
          if (state == S_DRD && cell_ok) begin
            state <= S_DWR;
          end else if (cell_last) begin
            state <= S_FIN;
          end else begin
            state <= S_DRD;
            if (ox == 2'd2) begin
              ox <= 2'd0;
              if (oy == ((deff >= 2'd2) ? 2'd2 : 2'd1)) begin
                oy <= (deff >= 2'd2) ? 2'd0 : 2'd1;
                oz <= oz + 2'd1;
              end else begin
                oy <= oy + 2'd1;
              end
            end else begin
              ox <= ox + 2'd1;
            end
          end
        end
        S_RRD: state <= S_RDONE;
        S_RDONE: begin
          res_dens <= dn_rdata;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            status    <= res_status;
            cell_x    <= IdxW'(cx);
            cell_y    <= IdxW'(cy);
            cell_z    <= IdxW'(cz);
            in_bulge  <= res_bulge;
            density   <= res_dens;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> req_stall)
    else $error("item taken during clearing pass");

  a_bound_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_STEP_BOUND) |->
      (cell_x == '0 && cell_y == '0 && cell_z == '0 && !in_bulge))
    else $error("step-bound result carries cell data");

  a_dens_write: assert property (@(posedge clk) disable iff (rst)
    dn_we |-> (state == S_CLR || state == S_DWR || state == S_RDONE))
    else $error("density written outside update");

endmodule

[bench/tb.sv]
// Testbench for particle_mesh_density_deposit_core: random and directed items
// checked against a scoreboard that predicts every result transaction.
// Depends on pmdd_pkg and the RTL of the block.
module tb;
  import pmdd_pkg::*;

  localparam int Limit = 3000000;
  localparam int Drain = 300;

  typedef struct {
    opcode_t            op;
    logic [4:0]         gi;
    logic signed [31:0] cv, px, py, pz;
    logic [31:0]        mass;
    logic [4:0]         rx, ry, rz;
  } deposit_req_t;

  typedef struct {
    status_t     st;
    logic [4:0]  cx, cy, cz;
    logic        ib;
    logic [47:0] dens;
  } deposit_rsp_t;

  class density_board;
    int           fails;
    deposit_rsp_t pending_q[$];
    bit [1:0]     dims;
    bit [5:0]     pts;
    bit [30:0]    spc;
    bit           ben;
    bit [30:0]    brad;
    bit [16:0]    bfrac;
    bit signed [31:0] grid[32];
    bit [47:0]    cells[32768];

    function new();
      dims = DimsReset;
      pts = PointsReset;
      spc = SpaceReset;
      ben = 0;
      brad = 0;
      bfrac = FracOne;
    endfunction

    function int points();
      int n;
      n = pts;
      if (n < 2) n = 2;
      if (n > 32) n = 32;
      return n;
    endfunction

    function void set_reg(cfg_idx_t i, bit [30:0] v);
      case (i)
        CFG_DIMS:   dims = v[1:0];
        CFG_POINTS: pts = v[5:0];
        CFG_SPACE:  spc = v;
        CFG_BEN:    ben = v[0];
        CFG_BRAD:   brad = v;
        CFG_BFRAC:  bfrac = v[16:0];
        default: ;
      endcase
    endfunction

    function bit find_cell(int n, longint pos, output int found_cell);
      int lo, hi, mid;
      longint p2, sp, g2;
      lo = 0;
      hi = n - 1;
      p2 = pos * 2;
      sp = longint'(spc);
      found_cell = 0;
      for (int s = 0; s < SearchLimit; s++) begin
        mid = (lo + hi) / 2;
        g2 = longint'(grid[mid]) * 2;
        if (p2 < g2 + sp && p2 > g2 - sp) begin
          found_cell = mid;
          return 1;
        end
        if (p2 >= g2 + sp) begin
          if (mid == n - 2) begin
            found_cell = n - 1;
            return 1;
          end
          lo = mid;
        end else begin
          if (mid == 0) begin
            found_cell = 0;
            return 1;
          end
          hi = mid;
        end
      end
      return 0;
    endfunction

    function longint unsigned mag(bit signed [31:0] v);
      longint g;
      g = v;
      return (g < 0) ? -g : g;
    endfunction

    function void take_req(deposit_req_t r);
      deposit_rsp_t e;
      int n, d, x, y, z, a;
      bit ok;
      longint unsigned share, dd, rr, f, dv, s, mass;
      n = points();
      e.st = ST_OK;
      e.cx = 0;
      e.cy = 0;
      e.cz = 0;
      e.ib = 0;
      e.dens = 0;
      x = 0;
      y = 0;
      z = 0;
      case (r.op)
        OP_WRITE_COORD: grid[r.gi] = r.cv;
        OP_DEPOSIT: begin
          d = (dims == 0) ? 1 : dims;
          ok = find_cell(n, r.px, x);
          if (ok && d >= 2) ok = find_cell(n, r.py, y);
          if (ok && d >= 3) ok = find_cell(n, r.pz, z);
          if (!ok) begin
            e.st = ST_STEP_BOUND;
          end else begin
            mass = r.mass;
            dv = (d == 1) ? 3 : (d == 2) ? 9 : 27;
            share = mass / dv;
            if (d == 3 && ben) begin
              dd = mag(grid[x]) * mag(grid[x]) + mag(grid[y]) * mag(grid[y])
                   + mag(grid[z]) * mag(grid[z]);
              rr = longint'(brad) * longint'(brad);
              if (dd < rr) begin
                f = (bfrac > FracOne) ? FracOne : bfrac;
                share = (mass * f) / (dv << 16);
                e.ib = 1;
              end
            end
            for (int k = z - 1; k <= z + 1; k++) begin
              if (k < 0 || k >= n || (d < 3 && k != z)) continue;
              for (int j = y - 1; j <= y + 1; j++) begin
                if (j < 0 || j >= n || (d < 2 && j != y)) continue;
                for (int i = x - 1; i <= x + 1; i++) begin
                  if (i < 0 || i >= n) continue;
                  a = (k * 32 + j) * 32 + i;
                  s = cells[a] + share;
                  cells[a] = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
                end
              end
            end
            e.cx = 5'(x);
            e.cy = 5'(y);
            e.cz = 5'(z);
          end
        end
        default: begin
          if (r.rx >= n || r.ry >= n || r.rz >= n) begin
            e.st = ST_RANGE;
          end else begin
            a = (int'(r.rz) * 32 + int'(r.ry)) * 32 + int'(r.rx);
            e.dens = cells[a];
            if (r.op == OP_READ_CLEAR) cells[a] = 0;
          end
        end
      endcase
      pending_q.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fails++;
    endtask

    task check_rsp(deposit_rsp_t got);
      deposit_rsp_t w;
      if (pending_q.size() == 0) begin
        report("unexpected transaction", got.st, 0);
      end else begin
        w = pending_q.pop_front();
        if (got.st !== w.st) report("status", got.st, w.st);
        if (got.cx !== w.cx) report("cell_x", got.cx, w.cx);
        if (got.cy !== w.cy) report("cell_y", got.cy, w.cy);
        if (got.cz !== w.cz) report("cell_z", got.cz, w.cz);
        if (got.ib !== w.ib) report("in_bulge", got.ib, w.ib);
        if (got.dens !== w.dens) report("density", got.dens, w.dens);
      end
    endtask
  endclass

  logic clk, rst, req_valid, req_stall, rsp_valid, rsp_stall;
  logic [OpW-1:0] opcode;
  logic [IdxW-1:0] grid_index, read_x, read_y, read_z;
  logic signed [CoordW-1:0] coord_value, pos_x, pos_y, pos_z;
  logic [MassW-1:0] particle_mass;
  logic [StatW-1:0] status;
  logic [IdxW-1:0] cell_x, cell_y, cell_z;
  logic in_bulge;
  logic [DensW-1:0] density;
  logic cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  density_board sb;
  int cycles, stall_pct, hold_left, burst_left, gap_max;
  longint tbl_step;

  particle_mesh_density_deposit_core uut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    deposit_rsp_t got;
    if (!rst && rsp_valid && !rsp_stall) begin
      got.st = status_t'(status);
      got.cx = cell_x;
      got.cy = cell_y;
      got.cz = cell_z;
      got.ib = in_bulge;
      got.dens = density;
      sb.check_rsp(got);
    end
  end

  initial begin
    rsp_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall = 1;
        hold_left--;
      end else begin
        rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // entered and left at a falling edge; valid stays high after acceptance
  task send_req(deposit_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_valid = 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    opcode = r.op;
    grid_index = r.gi;
    coord_value = r.cv;
    pos_x = r.px;
    pos_y = r.py;
    pos_z = r.pz;
    particle_mass = r.mass;
    read_x = r.rx;
    read_y = r.ry;
    read_z = r.rz;
    req_valid = 1;
    do @(posedge clk); while (req_stall);
    sb.take_req(r);
    @(negedge clk);
  endtask

  task drain();
    req_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(cfg_idx_t i, bit [30:0] v);
    cfg_write = 1;
    cfg_index = i;
    cfg_data = v;
    @(posedge clk);
    sb.set_reg(i, v);
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic deposit_req_t noise();
    deposit_req_t r;
    r.op = opcode_t'($urandom_range(0, 3));
    r.gi = $urandom;
    r.cv = $urandom;
    r.px = $urandom;
    r.py = $urandom;
    r.pz = $urandom;
    r.mass = $urandom;
    r.rx = $urandom;
    r.ry = $urandom;
    r.rz = $urandom;
    return r;
  endfunction

  task load_grid(longint base, bit scramble);
    deposit_req_t r;
    for (int i = 0; i < 32; i++) begin
      r = noise();
      r.op = OP_WRITE_COORD;
      r.gi = i;
      r.cv = clip32(base + i * tbl_step);
      if (scramble && $urandom_range(0, 3) == 0) r.cv = $urandom;
      send_req(r);
    end
  endtask

  function automatic logic signed [31:0] near_pos();
    longint off;
    if ($urandom_range(0, 99) < 15) return $urandom;
    off = longint'($urandom_range(0, 2 * tbl_step)) - tbl_step;
    return clip32(longint'(sb.grid[$urandom_range(0, 31)]) + off);
  endfunction

  task send_random();
    deposit_req_t r;
    int w, n;
    r = noise();
    n = sb.points();
    w = $urandom_range(0, 99);
    if (w < 50) begin
      r.op = OP_DEPOSIT;
      r.px = near_pos();
      r.py = near_pos();
      r.pz = near_pos();
    end else if (w < 88) begin
      r.op = (w < 70) ? OP_READ : OP_READ_CLEAR;
      if ($urandom_range(0, 4) != 0) begin
        r.rx = $urandom_range(0, n - 1);
        r.ry = (sb.dims >= 2) ? $urandom_range(0, n - 1) : 0;
        r.rz = (sb.dims == 3) ? $urandom_range(0, n - 1) : 0;
      end
    end else begin
      r.op = OP_WRITE_COORD;
      if (w < 97) r.cv = near_pos();
    end
    send_req(r);
  endtask

  task directed();
    deposit_req_t r;
    r = noise();
    r.op = OP_DEPOSIT;
    r.px = 0; r.py = 0; r.pz = 0; r.mass = 32'h0001_0000;
    send_req(r);
    r.px = 32'sh8000_0000; r.py = 32'sh8000_0000; r.pz = 32'sh8000_0000;
    r.mass = '1;
    send_req(r);
    r.px = 32'sh7fff_ffff; r.py = 32'sh7fff_ffff; r.pz = 32'sh7fff_ffff;
    send_req(r);
    r.px = 32768; r.py = -32768; r.pz = 32767; r.mass = 0;
    send_req(r);
    r.op = OP_READ;
    r.rx = 16; r.ry = 16; r.rz = 16;
    send_req(r);
    r.op = OP_READ_CLEAR;
    send_req(r);
    r.op = OP_READ;
    send_req(r);
    r.rx = 31; r.ry = 31; r.rz = 31;
    send_req(r);
    r.rx = 0; r.ry = 0; r.rz = 0;
    send_req(r);
  endtask

  initial begin
    bit [30:0] rads;
    bit [16:0] fracs[4];
    bit [5:0] ptsl[7];
    bit [30:0] spcv;
    sb = new();
    cycles = 0;
    stall_pct = 0;
    hold_left = 0;
    burst_left = 0;
    gap_max = 0;
    tbl_step = 65536;
    fracs = '{17'd0, 17'd65536, 17'h1ffff, 17'd40000};
    ptsl = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd17, 6'd5};
    rst = 1;
    req_valid = 0;
    opcode = OP_WRITE_COORD;
    grid_index = 0;
    coord_value = 0;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    particle_mass = 0;
    read_x = 0;
    read_y = 0;
    read_z = 0;
    cfg_write = 0;
    cfg_index = CFG_DIMS;
    cfg_data = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    load_grid(-16 * tbl_step, 0);
    directed();
    repeat (40) send_random();

    for (int p = 1; p <= 7; p++) begin
      drain();
      stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 70;
      gap_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 12;
      tbl_step = $urandom_range(1, 1 << 20);
      spcv = (p % 2) ? tbl_step : tbl_step / 2;
      if (p == 3) spcv = 0;
      if (p == 5) spcv = 31'h7fff_ffff;
      rads = (p == 3) ? 31'h7fff_ffff : $urandom_range(0, 20) * tbl_step;
      write_reg(CFG_DIMS, p % 4);
      write_reg(CFG_POINTS, ptsl[p - 1]);
      write_reg(CFG_SPACE, spcv);
      write_reg(CFG_BEN, p >= 3);
      write_reg(CFG_BRAD, rads);
      write_reg(CFG_BFRAC, fracs[p % 4]);
      load_grid(-16 * tbl_step + $urandom_range(0, tbl_step), p == 6);
      if (p == 2) hold_left = 600;
      for (int i = 0; i < 20; i++) begin
        if (p == 4 && i == 10) drain();
        send_random();
      end
    end

    drain();
    if (sb.fails == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

[sim.f]
sv/pmdd_pkg.sv
sv/pmdd_ram.sv
sv/particle_mesh_density_deposit_core.sv
bench/tb.sv
